// ----- rtl/zipdec_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the legacy ZIP stream decryptor.
// Used by every module under rtl; depends on nothing.
package zipdec_pkg;

    localparam int unsigned TableDepth = 256;
    localparam int unsigned TabAw      = $clog2(TableDepth);
    localparam int unsigned WordW      = 32;

    localparam logic [WordW-1:0] KEY_A_INIT = 32'd305419896;
    localparam logic [WordW-1:0] KEY_B_INIT = 32'd591751049;
    localparam logic [WordW-1:0] KEY_C_INIT = 32'd878082192;
    localparam logic [WordW-1:0] KEY_B_MULT = 32'd134775813;

    typedef enum logic [1:0] {
        REQ_LOAD     = 2'd0,
        REQ_START    = 2'd1,
        REQ_PASSWORD = 2'd2,
        REQ_CIPHER   = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type          req_type;
        logic [TabAw-1:0]   table_index;
        logic [WordW-1:0]   table_word;
        logic [7:0]         data_byte;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       utf8_ok;
        logic       end_of_text;
    } t_out_item;

    // UTF-8 check state: continuation bytes still expected, sticky violation
    typedef struct packed {
        logic [1:0] pending;
        logic       viol;
    } t_utf8_st;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KSTREAM,
        ST_DECRYPT,
        ST_KEYA,
        ST_KEYB_MUL,
        ST_KEYB_ADD,
        ST_KEYC
    } t_state;

endpackage

// ----- rtl/zipdec_table.sv -----
`timescale 1ns / 1ps
// 256 x 32 mixing table: one write port, one read port with registered data.
// Depends on zipdec_pkg.
module zipdec_table (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [zipdec_pkg::TabAw-1:0]   i_waddr,
    input  logic [zipdec_pkg::WordW-1:0]   i_wdata,
    input  logic [zipdec_pkg::TabAw-1:0]   i_raddr,
    output logic [zipdec_pkg::WordW-1:0]   o_rdata
);
    import zipdec_pkg::*;

    logic [WordW-1:0] r_mem [TableDepth];
    logic [WordW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/zipdec_mul.sv -----
`timescale 1ns / 1ps
// Shared 32 x 32 multiplier, low word kept, product registered.
// Serves both the keystream square and the key_b update. Depends on zipdec_pkg.
module zipdec_mul (
    input  logic                         i_clk,
    input  logic [zipdec_pkg::WordW-1:0] i_a,
    input  logic [zipdec_pkg::WordW-1:0] i_b,
    output logic [zipdec_pkg::WordW-1:0] o_prod
);
    import zipdec_pkg::*;

    logic [WordW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/zipdec_utf8.sv -----
`timescale 1ns / 1ps
// UTF-8 plausibility step: next check state for one plain byte.
// Accepts 1-, 2- and 3-byte sequences only. Depends on zipdec_pkg.
module zipdec_utf8 (
    input  zipdec_pkg::t_utf8_st i_st,
    input  logic [7:0]           i_byte,
    output zipdec_pkg::t_utf8_st o_st
);
    import zipdec_pkg::*;

    always_comb begin
        o_st = i_st;
        if (i_st.pending != 2'd0) begin
            // expect 10xxxxxx; count down either way
            if (i_byte[7:6] != 2'b10) begin
                o_st.viol = 1'b1;
            end
            o_st.pending = i_st.pending - 2'd1;
        end else if (i_byte[7]) begin
            if (i_byte[7:5] == 3'b110) begin
                o_st.pending = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                o_st.pending = 2'd2;
            end else begin
                o_st.viol = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/zip_legacy_decrypt_utf8_check.sv -----
`timescale 1ns / 1ps
// Legacy ZIP stream decryptor with UTF-8 check: sequencer, keys, output register.
// Depends on zipdec_pkg, zipdec_table, zipdec_mul, zipdec_utf8.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+---------------------------
//  input   | i_in_valid | o_in_ready  | i_in_data  (t_in_item)
//  output  | o_out_valid| i_out_ready | o_out_data (t_out_item)
//
// Load and start items finish in the idle state; a password byte steps through
// decrypt, key_a, key_b mul/add and key_c, a cipher byte first through keystream,
// paced by the shared multiplier and the two dependent registered table reads.
// Reset (synchronous, active low) loads the initial keys and clears the check
// state; the table holds garbage until written. A stalled output holds a cipher
// byte in the last key step, so no input is taken until the result moves.
module zip_legacy_decrypt_utf8_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  zipdec_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output zipdec_pkg::t_out_item o_out_data
);
    import zipdec_pkg::*;

    t_state           r_state, n_state;
    t_req_type        r_type;
    logic [7:0]       r_data;
    logic             r_last;
    logic [7:0]       r_byte;
    logic [WordW-1:0] r_key_a, r_key_b, r_key_c;
    t_utf8_st         r_utf8, n_utf8;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             in_acc;
    logic             out_free;
    logic             tab_we;
    logic [TabAw-1:0] tab_raddr;
    logic [WordW-1:0] tab_rdata;
    logic [WordW-1:0] mul_a, mul_b, mul_prod;
    logic [15:0]      ks_t;
    logic [7:0]       plain;
    logic [WordW-1:0] kb_new;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign tab_we   = in_acc && (i_in_data.req_type == REQ_LOAD);
    assign ks_t     = r_key_c[15:0] | 16'h0002;
    assign plain    = (r_type == REQ_CIPHER) ? (r_data ^ mul_prod[15:8]) : r_data;
    assign kb_new   = mul_prod + 32'd1;

    zipdec_table u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (i_in_data.table_index),
        .i_wdata (i_in_data.table_word),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    zipdec_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    zipdec_utf8 u_utf8 (
        .i_st   (r_utf8),
        .i_byte (plain),
        .o_st   (n_utf8)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.req_type == REQ_CIPHER) begin
                        n_state = ST_KSTREAM;
                    end else if (i_in_data.req_type == REQ_PASSWORD) begin
                        n_state = ST_DECRYPT;
                    end
                end
            end
            ST_KSTREAM:  n_state = ST_DECRYPT;
            ST_DECRYPT:  n_state = ST_KEYA;
            ST_KEYA:     n_state = ST_KEYB_MUL;
            ST_KEYB_MUL: n_state = ST_KEYB_ADD;
            ST_KEYB_ADD: n_state = ST_KEYC;
            ST_KEYC: begin
                if (r_type != REQ_CIPHER || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: ready, multiplier operands, table read address
    always_comb begin
        o_in_ready = 1'b0;
        mul_a      = r_key_b + {24'd0, r_key_a[7:0]};
        mul_b      = KEY_B_MULT;
        tab_raddr  = r_key_c[7:0] ^ r_key_b[31:24];
        unique case (r_state)
            ST_IDLE:     o_in_ready = 1'b1;
            ST_KSTREAM: begin
                mul_a = {16'd0, ks_t};
                mul_b = {16'd0, ks_t ^ 16'h0001};
            end
            ST_DECRYPT:  tab_raddr = r_key_a[7:0] ^ plain;
            ST_KEYB_ADD: tab_raddr = r_key_c[7:0] ^ kb_new[31:24];
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key_a     <= KEY_A_INIT;
            r_key_b     <= KEY_B_INIT;
            r_key_c     <= KEY_C_INIT;
            r_utf8      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_KEYC && r_type == REQ_CIPHER && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_in_data.req_type == REQ_START) begin
                        r_key_a <= KEY_A_INIT;
                        r_key_b <= KEY_B_INIT;
                        r_key_c <= KEY_C_INIT;
                        r_utf8  <= '0;
                    end
                end
                ST_DECRYPT: begin
                    if (r_type == REQ_CIPHER) begin
                        r_utf8 <= n_utf8;
                    end
                end
                ST_KEYA:     r_key_a <= tab_rdata ^ (r_key_a >> 8);
                ST_KEYB_ADD: r_key_b <= kb_new;
                ST_KEYC: begin
                    // hold here until the output register frees up
                    if (r_type != REQ_CIPHER || out_free) begin
                        r_key_c <= tab_rdata ^ (r_key_c >> 8);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_type <= i_in_data.req_type;
            r_data <= i_in_data.data_byte;
            r_last <= i_in_data.last;
        end
        if (r_state == ST_DECRYPT) begin
            r_byte <= plain;
        end
        if (r_state == ST_KEYC && r_type == REQ_CIPHER && out_free) begin
            r_out_data.plain_byte  <= r_byte;
            r_out_data.utf8_ok     <= !r_utf8.viol;
            r_out_data.end_of_text <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_utf8.pending != 2'd3)
        else $error("utf8 pending count out of range");

    a_viol_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_utf8.viol && !(in_acc && i_in_data.req_type == REQ_START)) |=> r_utf8.viol)
        else $error("utf8 violation cleared without a start transaction");

    a_kstream_cipher: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_KSTREAM |-> r_type == REQ_CIPHER)
        else $error("keystream step entered for a non-cipher transaction");

    a_result_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KEYC && r_type == REQ_CIPHER && out_free)
            |=> (r_out_valid && r_state == ST_IDLE))
        else $error("cipher result not issued on leaving the last key step");

endmodule
